>>> src/tsrw_pkg.sv
package tsrw_pkg;

    // Width of the segment byte counter; the counter saturates at its all-ones value.
    localparam int POSITION_BITS = 16;

    typedef logic [POSITION_BITS-1:0] pos_t;

    // Reset value of the watched port register.
    localparam logic [15:0] WATCHED_PORT_RESET = 16'd5001;

    // Byte offsets inside the TCP header.
    localparam int OFF_SRC_PORT_HI  = 0;
    localparam int OFF_SRC_PORT_LO  = 1;
    localparam int OFF_DST_PORT_HI  = 2;
    localparam int OFF_DST_PORT_LO  = 3;
    localparam int OFF_DATA_OFFSET  = 12;
    localparam int OFF_CHECKSUM_HI  = 16;
    localparam int OFF_CHECKSUM_LO  = 17;
    localparam int OFF_OPTIONS      = 20;

    // Header length below which no option walk takes place.
    localparam logic [5:0] MIN_HEADER_BYTES = 6'd30;

    // Option kinds and the smallest legal option length.
    localparam logic [7:0] OPT_KIND_NOP       = 8'd1;
    localparam logic [7:0] OPT_KIND_TIMESTAMP = 8'd8;
    localparam logic [7:0] OPT_MIN_LEN        = 8'd2;

    // Offsets of the timestamp fields relative to the option kind byte.
    localparam int TSVAL_FIRST = 2;
    localparam int TSVAL_LAST  = 5;
    localparam int TSECR_FIRST = 6;
    localparam int TSECR_LAST  = 9;

    // IP protocol number of TCP, part of the checksum pseudo-header.
    localparam logic [15:0] PROTO_TCP = 16'd6;

    // Option walk phases.
    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_SKIP = 2'd2,
        PH_DONE = 2'd3
    } walk_phase_t;

    // Per-byte results handed from the parse stage to the output stage.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic        ck_ok;
        logic        rtt_ok;
        logic [15:0] acc;
        logic [17:0] pseudo;
        logic [15:0] tcp_len;
        logic [31:0] now;
        logic [31:0] old_echo;
    } stage_t;

endpackage

>>> src/tcp_timestamp_rtt_rewriter_top.sv
// Pipeline: two register stages (parse stage, output stage); an accepted byte is registered in
// the parse stage, then in the output stage, and is held there while m_ready is low.
// Throughput: one byte per cycle unless m_ready stalls the output; the per-byte parse, rewrite
// and one's-complement add sit in the parse stage, pseudo-header fold and RTT subtract in output.
// Reset: aresetn is synchronous and active low; it empties both stages, clears the
// per-segment parse state and loads the watched port with 5001.
module tcp_timestamp_rtt_rewriter_top
    import tsrw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        s_direction,
    input  logic [31:0] s_stamp_now,
    input  logic [31:0] s_echo_value,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_dest_address,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    output logic        m_checksum_valid,
    output logic [15:0] m_new_checksum,
    output logic        m_rtt_valid,
    output logic [31:0] m_rtt_sample
);

    // Configuration and per-segment parse state.
    logic [15:0] watched_port_reg;
    pos_t        pos_reg, pos_next;
    logic [5:0]  header_bytes_reg, header_bytes_next;
    logic [7:0]  port_high_reg, port_high_next;
    logic        port_matched_reg, port_matched_next;
    walk_phase_t phase_reg, phase_next;
    logic [7:0]  skip_reg, skip_next;
    logic        found_reg, found_next;
    logic [5:0]  start_reg, start_next;
    logic [31:0] old_echo_reg, old_echo_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  held_reg, held_next;
    logic        half_reg, half_next;

    // Pipeline registers.
    logic        p1_valid_reg, p1_valid_next;
    stage_t      p1_reg, p1_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_last_reg, m_last_next;
    logic        m_ck_valid_reg, m_ck_valid_next;
    logic [15:0] m_ck_reg, m_ck_next;
    logic        m_rtt_valid_reg, m_rtt_valid_next;
    logic [31:0] m_rtt_reg, m_rtt_next;

    logic        advance;
    logic        s_accept;

    // Handshake: the output stage moves when empty or taken, the parse stage when it can drain.
    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // Header field capture for the current byte.
    logic [5:0]  hdr_cur;
    logic        active;
    logic        in_walk;

    always_comb begin
        port_high_next    = port_high_reg;
        port_matched_next = port_matched_reg;
        header_bytes_next = header_bytes_reg;
        if (pos_reg == pos_t'(OFF_SRC_PORT_HI) || pos_reg == pos_t'(OFF_DST_PORT_HI)) begin
            port_high_next = s_data_byte;
        end
        if ((pos_reg == pos_t'(OFF_SRC_PORT_LO) && !s_direction) ||
            (pos_reg == pos_t'(OFF_DST_PORT_LO) && s_direction)) begin
            port_matched_next = ({port_high_reg, s_data_byte} == watched_port_reg);
        end
        if (pos_reg == pos_t'(OFF_DATA_OFFSET)) begin
            header_bytes_next = {s_data_byte[7:4], 2'b00};
        end
        hdr_cur = header_bytes_next;
        active  = port_matched_next && (hdr_cur >= MIN_HEADER_BYTES);
        in_walk = active && (pos_reg >= pos_t'(OFF_OPTIONS)) && (phase_reg != PH_DONE);
    end

    // Option walk: next phase, skip count and timestamp location.
    logic [7:0] skip_dec;

    always_comb begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        found_next = found_reg;
        start_next = start_reg;
        skip_dec   = skip_reg - 8'd1;
        if (in_walk) begin
            case (phase_reg)
                PH_KIND: begin
                    if (pos_reg >= pos_t'(hdr_cur)) begin
                        phase_next = PH_DONE;
                    end else if (s_data_byte == OPT_KIND_NOP) begin
                        phase_next = PH_KIND;
                    end else if (s_data_byte == OPT_KIND_TIMESTAMP) begin
                        found_next = 1'b1;
                        start_next = pos_reg[5:0];
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (s_data_byte < OPT_MIN_LEN) begin
                        phase_next = PH_DONE;
                    end else if (s_data_byte == OPT_MIN_LEN) begin
                        phase_next = PH_KIND;
                    end else begin
                        skip_next  = s_data_byte - OPT_MIN_LEN;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0) begin
                        phase_next = PH_KIND;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Timestamp rewrite and TSecr capture.
    pos_t        rel;
    logic        in_stamp;
    logic [7:0]  ob;
    logic        rtt_ok;

    always_comb begin
        rel           = pos_reg - pos_t'(start_reg);
        in_stamp      = active && found_reg && (pos_reg > pos_t'(start_reg));
        ob            = s_data_byte;
        old_echo_next = old_echo_reg;
        rtt_ok        = 1'b0;
        if (in_stamp) begin
            if (!s_direction && rel >= pos_t'(TSVAL_FIRST) && rel <= pos_t'(TSVAL_LAST)) begin
                case (rel[1:0])
                    2'd2:    ob = s_stamp_now[31:24];
                    2'd3:    ob = s_stamp_now[23:16];
                    2'd0:    ob = s_stamp_now[15:8];
                    default: ob = s_stamp_now[7:0];
                endcase
            end else if (s_direction && rel >= pos_t'(TSECR_FIRST) &&
                         rel <= pos_t'(TSECR_LAST)) begin
                old_echo_next = {old_echo_reg[23:0], s_data_byte};
                case (rel[1:0])
                    2'd2:    ob = s_echo_value[31:24];
                    2'd3:    ob = s_echo_value[23:16];
                    2'd0:    ob = s_echo_value[15:8];
                    default: ob = s_echo_value[7:0];
                endcase
            end
            rtt_ok = s_direction && (rel >= pos_t'(TSECR_LAST));
        end
    end

    // Running one's-complement sum; an odd final byte is padded with a zero low byte.
    logic [7:0]  sb;
    logic        add_en;
    logic [15:0] word;
    logic [16:0] sum17;
    logic [15:0] acc_sum;
    logic [17:0] pseudo;

    always_comb begin
        sb = (pos_reg == pos_t'(OFF_CHECKSUM_HI) || pos_reg == pos_t'(OFF_CHECKSUM_LO)) ?
             8'd0 : ob;
        add_en    = half_reg || s_last_byte;
        word      = half_reg ? {held_reg, sb} : {sb, 8'd0};
        sum17     = {1'b0, acc_reg} + {1'b0, word};
        acc_sum   = add_en ? (sum17[15:0] + {15'd0, sum17[16]}) : acc_reg;
        held_next = half_reg ? held_reg : sb;
        half_next = !half_reg;
        pos_next  = (pos_reg == '1) ? pos_reg : pos_reg + pos_t'(1);
        acc_next  = acc_sum;
        pseudo    = {2'b00, s_source_address[31:16]} + {2'b00, s_source_address[15:0]} +
                    {2'b00, s_dest_address[31:16]} + {2'b00, s_dest_address[15:0]};
    end

    // Parse stage payload.
    always_comb begin
        p1_next.out_byte = ob;
        p1_next.last     = s_last_byte;
        p1_next.ck_ok    = s_last_byte && active;
        p1_next.rtt_ok   = s_last_byte && rtt_ok;
        p1_next.acc      = acc_sum;
        p1_next.pseudo   = pseudo;
        p1_next.tcp_len  = 16'(pos_next);
        p1_next.now      = s_stamp_now;
        p1_next.old_echo = old_echo_next;
    end

    // Watched port and parse state registers; the parse state returns to its cleared value after a last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watched_port_reg <= WATCHED_PORT_RESET;
        end else if (cfg_wr_en) begin
            watched_port_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (s_accept && s_last_byte)) begin
            pos_reg          <= '0;
            header_bytes_reg <= '0;
            port_high_reg    <= '0;
            port_matched_reg <= 1'b0;
            phase_reg        <= PH_KIND;
            skip_reg         <= '0;
            found_reg        <= 1'b0;
            start_reg        <= '0;
            old_echo_reg     <= '0;
            acc_reg          <= '0;
            held_reg         <= '0;
            half_reg         <= 1'b0;
        end else if (s_accept) begin
            pos_reg          <= pos_next;
            header_bytes_reg <= header_bytes_next;
            port_high_reg    <= port_high_next;
            port_matched_reg <= port_matched_next;
            phase_reg        <= phase_next;
            skip_reg         <= skip_next;
            found_reg        <= found_next;
            start_reg        <= start_next;
            old_echo_reg     <= old_echo_next;
            acc_reg          <= acc_next;
            held_reg         <= held_next;
            half_reg         <= half_next;
        end
    end

    // Output stage: pseudo-header fold, checksum complement and RTT.
    logic [18:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        total = {3'b000, p1_reg.acc} + {1'b0, p1_reg.pseudo} + {3'b000, p1_reg.tcp_len} +
                {3'b000, PROTO_TCP};
        fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};

        p1_valid_next    = s_accept ? 1'b1 : (advance ? 1'b0 : p1_valid_reg);
        m_valid_next     = advance ? p1_valid_reg : m_valid_reg;
        m_byte_next      = p1_reg.out_byte;
        m_last_next      = p1_reg.last;
        m_ck_valid_next  = p1_reg.ck_ok;
        m_ck_next        = p1_reg.ck_ok ? ~fold2 : 16'd0;
        m_rtt_valid_next = p1_reg.rtt_ok;
        m_rtt_next       = p1_reg.rtt_ok ? (p1_reg.now - p1_reg.old_echo) : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_reg <= p1_next;
        end
        if (advance && p1_valid_reg) begin
            m_byte_reg      <= m_byte_next;
            m_last_reg      <= m_last_next;
            m_ck_valid_reg  <= m_ck_valid_next;
            m_ck_reg        <= m_ck_next;
            m_rtt_valid_reg <= m_rtt_valid_next;
            m_rtt_reg       <= m_rtt_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = m_byte_reg;
    assign m_out_last       = m_last_reg;
    assign m_checksum_valid = m_ck_valid_reg;
    assign m_new_checksum   = m_ck_reg;
    assign m_rtt_valid      = m_rtt_valid_reg;
    assign m_rtt_sample     = m_rtt_reg;

    // A checksum or RTT result only ever comes with the final byte of a segment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_checksum_valid || m_rtt_valid) |-> m_out_last)
        else $error("checksum or RTT reported on a non-final byte");

    // Unreported checksum and RTT fields read as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_checksum_valid && !m_rtt_valid |-> m_new_checksum == 16'd0 &&
        m_rtt_sample == 32'd0)
        else $error("unreported checksum or RTT field is not zero");

    // The parse state is cleared after the final byte of a segment is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_last_byte |=> pos_reg == '0 && phase_reg == PH_KIND && !half_reg &&
        acc_reg == 16'd0)
        else $error("parse state not cleared after the final byte");

    // The stages never hold more transactions than they have room for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !advance |-> !s_ready)
        else $error("input accepted while both stages are full");

endmodule
